// ===== sv/c_comment_stripper_macros.svh =====
// Assertion macros for the comment stripper.
`ifndef C_COMMENT_STRIPPER_MACROS_SVH
`define C_COMMENT_STRIPPER_MACROS_SVH

`ifndef SYNTHESIS

`define CCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ccs assertion failed");

`define CCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ccs assertion failed");

`else

`define CCS_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define CCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/ccs_pkg.sv =====
package ccs_pkg;

  localparam logic [7:0] SLASH_CH   = 8'h2F;
  localparam logic [7:0] STAR_CH    = 8'h2A;
  localparam logic [7:0] NEWLINE_CH = 8'h0A;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_HELD   = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4
  } scan_mode_e;

  // one queue entry: up to two result beats caused by one input byte
  typedef struct packed {
    logic [7:0] ch0;
    logic       val0;
    logic       two;
    logic [7:0] ch1;
    logic       text_end;
  } ccs_entry_t;

endpackage

// ===== sv/ccs_front.sv =====
module ccs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_char_i,
  input  logic                is_last_i,
  input  logic                q_full_i,
  output logic                push_o,
  output ccs_pkg::ccs_entry_t entry_o
);

  ccs_pkg::scan_mode_e mode_q, mode_d, mode_step;
  logic       accept;
  logic       is_slash, is_star, is_nl;
  logic [1:0] cnt;
  logic [7:0] ch0;
  logic       val0;

  assign is_slash   = (in_char_i == ccs_pkg::SLASH_CH);
  assign is_star    = (in_char_i == ccs_pkg::STAR_CH);
  assign is_nl      = (in_char_i == ccs_pkg::NEWLINE_CH);
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // next state
  always_comb begin
    mode_step = ccs_pkg::MODE_NORMAL;
    unique case (mode_q)
      ccs_pkg::MODE_HELD: begin
        if (is_slash) begin
          mode_step = ccs_pkg::MODE_LINE;
        end else if (is_star) begin
          mode_step = ccs_pkg::MODE_BLOCK;
        end else begin
          mode_step = ccs_pkg::MODE_NORMAL;
        end
      end
      ccs_pkg::MODE_LINE: begin
        mode_step = is_nl ? ccs_pkg::MODE_NORMAL : ccs_pkg::MODE_LINE;
      end
      ccs_pkg::MODE_BLOCK: begin
        mode_step = is_star ? ccs_pkg::MODE_STAR : ccs_pkg::MODE_BLOCK;
      end
      ccs_pkg::MODE_STAR: begin
        if (is_slash) begin
          mode_step = ccs_pkg::MODE_NORMAL;
        end else if (is_star) begin
          mode_step = ccs_pkg::MODE_STAR;
        end else begin
          mode_step = ccs_pkg::MODE_BLOCK;
        end
      end
      default: begin
        mode_step = is_slash ? ccs_pkg::MODE_HELD : ccs_pkg::MODE_NORMAL;
      end
    endcase
    mode_d = mode_q;
    if (accept) begin
      mode_d = is_last_i ? ccs_pkg::MODE_NORMAL : mode_step;
    end
  end

  // outputs
  always_comb begin
    cnt  = 2'd0;
    ch0  = in_char_i;
    val0 = 1'b1;
    unique case (mode_q)
      ccs_pkg::MODE_HELD: begin
        if (!is_slash && !is_star) begin
          cnt = 2'd2;
          ch0 = ccs_pkg::SLASH_CH;
        end
      end
      ccs_pkg::MODE_LINE: begin
        if (is_nl) begin
          cnt = 2'd1;
        end
      end
      ccs_pkg::MODE_BLOCK, ccs_pkg::MODE_STAR: begin
        if (is_nl && !is_last_i) begin
          cnt = 2'd1;
        end
      end
      default: begin
        if (!is_slash) begin
          cnt = 2'd1;
        end
      end
    endcase
    if (is_last_i && cnt == 2'd0) begin
      cnt = 2'd1;
      if (mode_step == ccs_pkg::MODE_HELD) begin
        ch0 = ccs_pkg::SLASH_CH;
      end else begin
        ch0  = 8'h00;
        val0 = 1'b0;
      end
    end
    push_o           = accept & (cnt != 2'd0);
    entry_o.ch0      = ch0;
    entry_o.val0     = val0;
    entry_o.two      = (cnt == 2'd2);
    entry_o.ch1      = in_char_i;
    entry_o.text_end = is_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ccs_pkg::MODE_NORMAL;
    end else begin
      mode_q <= mode_d;
    end
  end

endmodule

// ===== sv/ccs_queue.sv =====
module ccs_queue #(
  parameter int unsigned Depth = ccs_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ccs_pkg::ccs_entry_t push_entry_i,
  output logic                full_o,
  output logic                head_valid_o,
  output ccs_pkg::ccs_entry_t head_o,
  input  logic                pop_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  ccs_pkg::ccs_entry_t slots_q [Depth];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slots_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== sv/ccs_back.sv =====
module ccs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  ccs_pkg::ccs_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_char_o,
  output logic                char_valid_o,
  output logic                run_last_o,
  output logic                text_end_o
);

  // phase_q set: second beat of a two-beat entry
  logic phase_q, phase_d;
  logic accept;

  assign out_valid_o  = head_valid_i;
  assign out_char_o   = phase_q ? head_i.ch1 : head_i.ch0;
  assign char_valid_o = phase_q | head_i.val0;
  assign run_last_o   = phase_q | ~head_i.two;
  assign text_end_o   = head_i.text_end & run_last_o;
  assign accept       = head_valid_i & ~out_stall_i;
  assign pop_o        = accept & run_last_o;
  assign phase_d      = accept ? ~run_last_o : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== sv/c_comment_stripper.sv =====
// channel | valid      | stall       | beat
// --------+------------+-------------+------------------------------------------------
// in      | in_valid_i | in_stall_o  | in_char_i, is_last_i
// out     | out_valid_o| out_stall_i | out_char_o, char_valid_o, run_last_o, text_end_o
//
// One input byte per cycle while in_stall_o is low; the scan mode register in the front
// carries the scan state. Each byte leaves 0, 1 or 2 result beats in the queue;
// the back sends one beat per cycle while out_stall_i is low, so a two-beat entry goes
// out as two beats. Entries are registered in the queue. Reset: no clearing pass.
// in_stall_o rises only when the queue (Depth entries) is full.
`include "c_comment_stripper_macros.svh"

module c_comment_stripper #(
  parameter int unsigned QueueDepth = ccs_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       run_last_o,
  output logic       text_end_o
);

  ccs_pkg::ccs_entry_t push_entry, head;
  logic q_full, q_push, q_pop, head_valid;

  ccs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_char_i  (in_char_i),
    .is_last_i  (is_last_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .entry_o    (push_entry)
  );

  ccs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (q_pop)
  );

  ccs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .char_valid_o (char_valid_o),
    .run_last_o   (run_last_o),
    .text_end_o   (text_end_o)
  );

  `CCS_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, q_push, !q_full)
  `CCS_ASSERT_IMPL(a_bare_only_at_end, clk_i, rst_ni, out_valid_o && !char_valid_o, text_end_o)
  `CCS_ASSERT_IMPL(a_end_closes_run, clk_i, rst_ni, out_valid_o && text_end_o, run_last_o)
  `CCS_ASSERT_IMPL(a_pop_needs_head, clk_i, rst_ni, q_pop, head_valid)

endmodule

// ===== tb/sv/c_comment_stripper_tb.sv =====
module c_comment_stripper_tb;

  typedef struct packed {
    logic [7:0] chr;
    logic       chr_ok;
    logic       run_end;
    logic       txt_end;
  } beat_t;

  localparam logic [1:0] ROW_PRED = 2'd0;
  localparam logic [1:0] ROW_NONE = 2'd1;
  localparam logic [1:0] ROW_ONE  = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [1:0] kind;
    beat_t      want;
  } row_t;

  localparam beat_t NO_BEAT = '0;

  localparam int N_ROWS     = 25;
  localparam int N_RANDOM   = 1500;
  localparam int IDLE_LIMIT = 2000;

  localparam int RX_OPEN  = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;
  localparam int RX_COMB  = 3;

  localparam row_t DIR_ROWS [N_ROWS] = '{
    {8'h61,      1'b0, ROW_ONE,  {8'h61, 1'b1, 1'b1, 1'b0}},
    {8'h00,      1'b0, ROW_ONE,  {8'h00, 1'b1, 1'b1, 1'b0}},
    {8'hFF,      1'b0, ROW_ONE,  {8'hFF, 1'b1, 1'b1, 1'b0}},
    {ccs_pkg::SLASH_CH,   1'b0, ROW_NONE, NO_BEAT},
    {8'h78,               1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::SLASH_CH,   1'b0, ROW_NONE, NO_BEAT},
    {ccs_pkg::SLASH_CH,   1'b0, ROW_NONE, NO_BEAT},
    {8'h71,               1'b0, ROW_NONE, NO_BEAT},
    {ccs_pkg::NEWLINE_CH, 1'b0, ROW_ONE,  {ccs_pkg::NEWLINE_CH, 1'b1, 1'b1, 1'b0}},
    {ccs_pkg::SLASH_CH,   1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::STAR_CH,    1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::SLASH_CH,   1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::NEWLINE_CH, 1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::STAR_CH,    1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::STAR_CH,    1'b0, ROW_PRED, NO_BEAT},
    {8'h6B,               1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::STAR_CH,    1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::NEWLINE_CH, 1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::STAR_CH,    1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::SLASH_CH,   1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::SLASH_CH,   1'b1, ROW_ONE,  {ccs_pkg::SLASH_CH, 1'b1, 1'b1, 1'b1}},
    {ccs_pkg::SLASH_CH,   1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::STAR_CH,    1'b0, ROW_PRED, NO_BEAT},
    {ccs_pkg::NEWLINE_CH, 1'b1, ROW_ONE,  {8'h00, 1'b0, 1'b1, 1'b1}},
    {8'h7A,               1'b1, ROW_ONE,  {8'h7A, 1'b1, 1'b1, 1'b1}}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_char_i;
  logic       is_last_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_char_o;
  logic       char_valid_o;
  logic       run_last_o;
  logic       text_end_o;

  ccs_pkg::scan_mode_e text_mode;
  beat_t      clean_q [$];
  int         bytes_sent   = 0;
  int         miss_cnt     = 0;
  int         quiet_cycles = 0;
  int         burst_left   = 0;
  logic       hold_req     = 1'b0;
  int         hold_left    = 0;
  int         style_left   = 0;
  int         stall_style  = RX_OPEN;
  int         rx_phase     = 0;

  c_comment_stripper u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_char_i    (in_char_i),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .char_valid_o (char_valid_o),
    .run_last_o   (run_last_o),
    .text_end_o   (text_end_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // advances the scan mode by one byte and returns the beats it yields
  function automatic int strip_step(input logic [7:0] c, input logic last,
                                    output beat_t [1:0] res);
    int   n     = 0;
    logic plain = 1'b0;
    res = '0;
    case (text_mode)
      ccs_pkg::MODE_HELD: begin
        if (c == ccs_pkg::SLASH_CH) text_mode = ccs_pkg::MODE_LINE;
        else if (c == ccs_pkg::STAR_CH) text_mode = ccs_pkg::MODE_BLOCK;
        else begin
          res[n] = {ccs_pkg::SLASH_CH, 1'b1, 2'b00};
          n++;
          plain = 1'b1;
        end
      end
      ccs_pkg::MODE_LINE: begin
        if (c == ccs_pkg::NEWLINE_CH) begin
          res[n] = {c, 1'b1, 2'b00};
          n++;
          text_mode = ccs_pkg::MODE_NORMAL;
        end
      end
      ccs_pkg::MODE_BLOCK: begin
        if (c == ccs_pkg::STAR_CH) text_mode = ccs_pkg::MODE_STAR;
        else if (c == ccs_pkg::NEWLINE_CH && !last) begin
          res[n] = {c, 1'b1, 2'b00};
          n++;
        end
      end
      ccs_pkg::MODE_STAR: begin
        if (c == ccs_pkg::SLASH_CH) text_mode = ccs_pkg::MODE_NORMAL;
        else if (c != ccs_pkg::STAR_CH) begin
          if (c == ccs_pkg::NEWLINE_CH && !last) begin
            res[n] = {c, 1'b1, 2'b00};
            n++;
          end
          text_mode = ccs_pkg::MODE_BLOCK;
        end
      end
      default: plain = 1'b1;
    endcase
    if (plain) begin
      if (c == ccs_pkg::SLASH_CH) text_mode = ccs_pkg::MODE_HELD;
      else begin
        text_mode = ccs_pkg::MODE_NORMAL;
        res[n] = {c, 1'b1, 2'b00};
        n++;
      end
    end
    if (last) begin
      if (text_mode == ccs_pkg::MODE_HELD) begin
        res[n] = {ccs_pkg::SLASH_CH, 1'b1, 2'b00};
        n++;
      end
      if (n == 0) begin
        res[0] = NO_BEAT;
        n = 1;
      end
      res[n-1].txt_end = 1'b1;
      text_mode = ccs_pkg::MODE_NORMAL;
    end
    if (n > 0) res[n-1].run_end = 1'b1;
    return n;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_byte(input row_t row);
    beat_t [1:0] res;
    int          n;
    in_char_i  = row.ch;
    is_last_i  = row.last;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    n = strip_step(row.ch, row.last, res);
    if (row.kind == ROW_PRED) begin
      for (int k = 0; k < n; k++) clean_q = {clean_q, res[k]};
    end else if (row.kind == ROW_ONE) begin
      clean_q = {clean_q, row.want};
    end
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic sender_pause();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
  endtask

  initial begin : stimulus
    int         len;
    int         pick;
    logic [7:0] ch;
    row_t       row;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_char_i   = 8'h00;
    is_last_i   = 1'b0;
    text_mode   = ccs_pkg::MODE_NORMAL;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      offer_byte(DIR_ROWS[i]);
      sender_pause();
    end

    hold_req = 1'b1;
    while (bytes_sent < N_ROWS + N_RANDOM) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 25);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0, 1, 2: ch = ccs_pkg::SLASH_CH;
          3, 4:    ch = ccs_pkg::STAR_CH;
          5:       ch = ccs_pkg::NEWLINE_CH;
          6, 7, 8: ch = 8'($urandom_range(32, 126));
          default: ch = 8'($urandom_range(0, 255));
        endcase
        row = {ch, (k == len - 1), ROW_PRED, NO_BEAT};
        offer_byte(row);
        if (bytes_sent == N_ROWS + N_RANDOM / 2) hold_req = 1'b1;
        sender_pause();
      end
    end
    in_valid_i = 1'b0;

    while (clean_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (miss_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: changing stall styles, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req    = 1'b0;
      hold_left   = 120;
      out_stall_i = 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(RX_OPEN, RX_COMB);
        style_left  = $urandom_range(20, 300);
      end
      style_left--;
      rx_phase++;
      case (stall_style)
        RX_OPEN:  out_stall_i = 1'b0;
        RX_LIGHT: out_stall_i = ($urandom_range(0, 9) < 3);
        RX_HEAVY: out_stall_i = ($urandom_range(0, 9) < 7);
        default:  out_stall_i = (rx_phase % 5 < 2);
      endcase
    end
  end

  always @(posedge clk_i) begin : out_check
    beat_t got;
    beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {out_char_o, char_valid_o, run_last_o, text_end_o};
      if (clean_q.size() == 0) begin
        if (miss_cnt < 10)
          $display("%0t: unexpected beat chr=%h ok=%b run_end=%b txt_end=%b",
                   $time, got.chr, got.chr_ok, got.run_end, got.txt_end);
        miss_cnt++;
      end else begin
        want = clean_q.pop_front();
        if (got.chr !== want.chr || got.chr_ok !== want.chr_ok ||
            got.run_end !== want.run_end || got.txt_end !== want.txt_end) begin
          if (miss_cnt < 10)
            $display("%0t: beat mismatch exp chr=%h ok=%b run_end=%b txt_end=%b, %s",
                     $time, want.chr, want.chr_ok, want.run_end, want.txt_end,
                     $sformatf("got chr=%h ok=%b run_end=%b txt_end=%b",
                               got.chr, got.chr_ok, got.run_end, got.txt_end));
          miss_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

endmodule
